// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GLC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/glc_pkg.sv -----
// ---------------------------------------------------------------------------
// glc_pkg
// Types, codes and constants of the glyph cell cache.
// ---------------------------------------------------------------------------
`default_nettype none
package glc_pkg;

  localparam int CELLS = 256;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_PROBE  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_FREE  = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_GROW  = 3'd4;
  localparam logic [2:0] ST_DROP  = 3'd5;

  localparam logic [2:0] REG_CELL_COUNT   = 3'd0;
  localparam logic [2:0] REG_COLUMNS      = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_ATLAS_WIDTH  = 3'd4;
  localparam logic [2:0] REG_ATLAS_HEIGHT = 3'd5;
  localparam logic [2:0] REG_MAX_WIDTH    = 3'd6;
  localparam logic [2:0] REG_MAX_HEIGHT   = 3'd7;

  typedef struct packed {
    logic [8:0]  cell_count;
    logic [8:0]  columns;
    logic [10:0] tile_w;
    logic [10:0] tile_h;
    logic [15:0] atlas_width;
    logic [15:0] atlas_height;
    logic [15:0] w_limit;
    logic [15:0] h_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FREE,
    KIND_SCAN
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic scan;
    logic resolve;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scan_last;
    logic  has_pos;
    logic  div_done;
    logic  out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/glyph_cell_cache_lru_core.sv -----
// ---------------------------------------------------------------------------
// glyph_cell_cache_lru_core
// Fully associative glyph cell cache, LRU replacement by frame stamps.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser opcode, tdata key, frame
// out_     out  tvalid/tready      tuser status, tdata index, x, y, evicted key
// cfg      in   APB psel/penable   8 registers at byte address 4*i
//
// One request at a time. A hit, or a full-cache insert that places, runs decide,
// a scan of the n configured cells at one read per cycle, drain, resolve, the index
// divider and output; a scanned miss, grow or drop skips the divider. An insert
// into a free cell goes from decide to the divider, a miss or drop with nothing
// to scan from decide to output. A result waiting on out_tready holds the next
// request in its output state only. Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
module glyph_cell_cache_lru_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_tuser,   // opcode
  input  wire logic [95:0]   in_tdata,   // key[63:0], frame[95:64]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [2:0]         out_tuser,  // status
  output logic [103:0]       out_tdata,  // cell_index, cell_x, cell_y, evicted_key, pad
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import glc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  glc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  glc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .stat, .cmd
  );

  glc_dp u_dp (
    .clk, .rst_n, .cfg, .cmd, .stat, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata
  );

endmodule
`default_nettype wire

// ----- src/glc_regs.sv -----
// ---------------------------------------------------------------------------
// glc_regs
// APB configuration registers with read-back.
// ---------------------------------------------------------------------------
`default_nettype none
module glc_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output glc_pkg::cfg_t     cfg
);
  import glc_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] sel;
  logic       wr;

  assign sel = paddr[4:2];
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_count   <= 9'd256;
      cfg_r.columns      <= 9'd16;
      cfg_r.tile_w       <= 11'd32;
      cfg_r.tile_h       <= 11'd32;
      cfg_r.atlas_width  <= 16'd512;
      cfg_r.atlas_height <= 16'd512;
      cfg_r.w_limit      <= 16'd512;
      cfg_r.h_limit      <= 16'd512;
    end else if (wr) begin
      unique case (sel)
        REG_CELL_COUNT:   cfg_r.cell_count   <= pwdata[8:0];
        REG_COLUMNS:      cfg_r.columns      <= pwdata[8:0];
        REG_CELL_WIDTH:   cfg_r.tile_w       <= pwdata[10:0];
        REG_CELL_HEIGHT:  cfg_r.tile_h       <= pwdata[10:0];
        REG_ATLAS_WIDTH:  cfg_r.atlas_width  <= pwdata[15:0];
        REG_ATLAS_HEIGHT: cfg_r.atlas_height <= pwdata[15:0];
        REG_MAX_WIDTH:    cfg_r.w_limit      <= pwdata[15:0];
        REG_MAX_HEIGHT:   cfg_r.h_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_CELL_COUNT:   prdata = {23'd0, cfg_r.cell_count};
      REG_COLUMNS:      prdata = {23'd0, cfg_r.columns};
      REG_CELL_WIDTH:   prdata = {21'd0, cfg_r.tile_w};
      REG_CELL_HEIGHT:  prdata = {21'd0, cfg_r.tile_h};
      REG_ATLAS_WIDTH:  prdata = {16'd0, cfg_r.atlas_width};
      REG_ATLAS_HEIGHT: prdata = {16'd0, cfg_r.atlas_height};
      REG_MAX_WIDTH:    prdata = {16'd0, cfg_r.w_limit};
      REG_MAX_HEIGHT:   prdata = {16'd0, cfg_r.h_limit};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/glc_ctrl.sv -----
// ---------------------------------------------------------------------------
// glc_ctrl
// Request sequencer: decide, scan, drain, resolve, divide, deliver.
// ---------------------------------------------------------------------------
`default_nettype none
module glc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire glc_pkg::stat_t stat,
  output glc_pkg::cmd_t       cmd
);
  import glc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        unique case (stat.kind)
          KIND_FREE: state_nxt = S_DIV;
          KIND_SCAN: state_nxt = S_SCAN;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_SCAN:    if (stat.scan_last) state_nxt = S_DRAIN;
      S_DRAIN:   state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = stat.has_pos ? S_DIV : S_OUT;
      S_DIV:     if (stat.div_done) state_nxt = S_OUT;
      S_OUT:     if (stat.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DECIDE:  cmd.decide   = 1'b1;
      S_SCAN:    cmd.scan     = 1'b1;
      S_RESOLVE: cmd.resolve  = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_OUT:     cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/glc_dp.sv -----
// ---------------------------------------------------------------------------
// glc_dp
// Cell store, scan compare, outcome, index divider and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module glc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire glc_pkg::cfg_t                     cfg,
  input  wire glc_pkg::cmd_t                     cmd,
  output glc_pkg::stat_t                         stat,
  input  wire logic [1:0]                        in_tuser,
  input  wire logic [glc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [2:0]                             out_tuser,
  output logic [glc_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import glc_pkg::*;

  logic [63:0] key_mem [CELLS];
  logic [31:0] frm_mem [CELLS];
  logic [CELLS-1:0] valid_r;
  logic [CNT_W-1:0] fill_r;

  logic [1:0]  op_r;
  logic [63:0] key_r;
  logic [31:0] frame_r;

  logic [CNT_W-1:0] addr_r;
  logic             pv_r;
  logic [IDX_W-1:0] paddr_r;
  logic [63:0]      key_q;
  logic [31:0]      frm_q;

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] min_idx_r;
  logic [31:0]      min_frm_r;
  logic             min_val_r;
  logic [63:0]      min_key_r;

  logic [2:0]  res_st_r;
  logic        res_pos_r;
  logic [63:0] res_ev_r;
  logic [IDX_W-1:0] idx_r;

  logic [7:0]  dq_r;
  logic [8:0]  rem_r;
  logic [2:0]  dcnt_r;

  logic        ov_r;
  logic [2:0]  ou_r;
  logic [OUT_DATA_W-1:0] od_r;

  logic [CNT_W-1:0] n;
  kind_t            kind;
  logic [8:0]       cols;
  logic             fv;
  logic [31:0]      feff;

  logic [2:0]       r_st;
  logic             r_pos;
  logic [IDX_W-1:0] r_idx;
  logic [63:0]      r_ev;
  logic             wk, wf;
  logic [IDX_W-1:0] waddr;

  logic [9:0]  dt;
  logic        dbit;
  logic [19:0] px;
  logic [18:0] py;
  logic [14:0] sx, sy;
  logic        grow_ok;

  function automatic logic [16:0] pow2_above(input logic [15:0] v);
    logic [15:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    return {1'b0, s} + 17'd1;
  endfunction

  always_comb begin
    logic [16:0] w, h;
    w = {1'b0, cfg.atlas_width};
    h = {1'b0, cfg.atlas_height};
    if (h <= w) h = pow2_above(cfg.atlas_height);
    else        w = pow2_above(cfg.atlas_width);
    grow_ok = ((cfg.atlas_width < cfg.w_limit) || (cfg.atlas_height < cfg.h_limit))
              && (w <= {1'b0, cfg.w_limit}) && (h <= {1'b0, cfg.h_limit});
  end

  assign n    = (cfg.cell_count > CNT_W'(CELLS)) ? CNT_W'(CELLS) : CNT_W'(cfg.cell_count);
  assign cols = (cfg.columns == 9'd0) ? 9'd1 : cfg.columns;

  always_comb begin
    case (op_r) inside
      OP_LOOKUP, OP_PROBE: kind = (n == '0) ? KIND_NONE : KIND_SCAN;
      OP_INSERT: kind = (n == '0) ? KIND_NONE : ((fill_r < n) ? KIND_FREE : KIND_SCAN);
      default:   kind = KIND_NONE;
    endcase
  end

  assign fv   = valid_r[paddr_r];
  assign feff = fv ? frm_q : 32'd0;

  // outcome of a finished scan
  always_comb begin
    r_st  = ST_MISS;
    r_pos = 1'b0;
    r_idx = '0;
    r_ev  = 64'd0;
    wk    = 1'b0;
    wf    = 1'b0;
    if (op_r == OP_INSERT) begin
      if (min_val_r && (min_frm_r == frame_r)) begin
        r_st = grow_ok ? ST_GROW : ST_DROP;
      end else begin
        r_st  = min_val_r ? ST_EVICT : ST_FREE;
        r_pos = 1'b1;
        r_idx = min_idx_r;
        r_ev  = min_val_r ? min_key_r : 64'd0;
        wk    = 1'b1;
        wf    = 1'b1;
      end
    end else if (hit_r) begin
      r_st  = ST_HIT;
      r_pos = 1'b1;
      r_idx = hit_idx_r;
      wf    = (op_r == OP_LOOKUP);
    end
  end

  assign waddr = cmd.decide ? fill_r[IDX_W-1:0] : r_idx;

  always_ff @(posedge clk) begin
    if ((cmd.decide && kind == KIND_FREE) || (cmd.resolve && wk)) key_mem[waddr] <= key_r;
    if ((cmd.decide && kind == KIND_FREE) || (cmd.resolve && wf)) frm_mem[waddr] <= frame_r;
    if (cmd.scan) begin
      key_q <= key_mem[addr_r[IDX_W-1:0]];
      frm_q <= frm_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      pv_r <= cmd.scan;
      if (cmd.decide && kind == KIND_FREE) begin
        valid_r[fill_r[IDX_W-1:0]] <= 1'b1;
        fill_r <= fill_r + CNT_W'(1);
      end
      if (cmd.resolve && wk) valid_r[r_idx] <= 1'b1;
      if (cmd.out_load)    ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      key_r   <= in_tdata[63:0];
      frame_r <= in_tdata[95:64];
    end
    if (cmd.decide) begin
      addr_r <= '0;
      hit_r  <= 1'b0;
    end
    if (cmd.scan) begin
      addr_r  <= addr_r + CNT_W'(1);
      paddr_r <= addr_r[IDX_W-1:0];
    end
    if (pv_r) begin
      if (!hit_r && fv && (key_q == key_r)) begin
        hit_r     <= 1'b1;
        hit_idx_r <= paddr_r;
      end
      if ((paddr_r == '0) || (feff < min_frm_r)) begin
        min_idx_r <= paddr_r;
        min_frm_r <= feff;
        min_val_r <= fv;
        min_key_r <= key_q;
      end
    end
    if (cmd.decide && kind != KIND_SCAN) begin
      res_st_r  <= (kind == KIND_FREE) ? ST_FREE : ((op_r == OP_INSERT) ? ST_DROP : ST_MISS);
      res_pos_r <= (kind == KIND_FREE);
      res_ev_r  <= 64'd0;
      idx_r     <= fill_r[IDX_W-1:0];
      dq_r      <= 8'(fill_r);
      rem_r     <= 9'd0;
      dcnt_r    <= 3'd0;
    end
    if (cmd.resolve) begin
      res_st_r  <= r_st;
      res_pos_r <= r_pos;
      res_ev_r  <= r_ev;
      idx_r     <= r_idx;
      dq_r      <= 8'(r_idx);
      rem_r     <= 9'd0;
      dcnt_r    <= 3'd0;
    end
    if (cmd.div_step) begin
      dq_r   <= {dq_r[6:0], dbit};
      rem_r  <= dbit ? 9'(dt - {1'b0, cols}) : dt[8:0];
      dcnt_r <= dcnt_r + 3'd1;
    end
    if (cmd.out_load) begin
      ou_r <= res_st_r;
      od_r <= {2'd0, res_ev_r,
               res_pos_r ? sy : 15'd0,
               res_pos_r ? sx : 15'd0,
               res_pos_r ? idx_r : 8'd0};
    end
  end

  assign dt   = {rem_r, dq_r[7]};
  assign dbit = (dt >= {1'b0, cols});
  assign px   = rem_r * cfg.tile_w;
  assign py   = dq_r * cfg.tile_h;
  assign sx   = (px > 20'd32767) ? 15'd32767 : px[14:0];
  assign sy   = (py > 19'd32767) ? 15'd32767 : py[14:0];

  assign stat.kind      = kind;
  assign stat.scan_last = (addr_r == n - CNT_W'(1));
  assign stat.has_pos   = r_pos;
  assign stat.div_done  = (dcnt_r == 3'd7);
  assign stat.out_free  = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tuser  = ou_r;
  assign out_tdata  = od_r;

endmodule
`default_nettype wire

// ----- src/glc_checker.sv -----
// ---------------------------------------------------------------------------
// glc_checker
// Port-level checks on the glyph cell cache, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module glc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [2:0]   out_tuser,
  input wire logic [103:0] out_tdata
);
  import glc_pkg::*;

  `GLC_ASSERT(a_status_range, out_tvalid, out_tuser <= ST_DROP)
  `GLC_ASSERT(a_miss_zero, out_tvalid && (out_tuser == ST_MISS), out_tdata[37:0] == 38'd0)
  `GLC_ASSERT(a_evict_key, out_tvalid && (out_tuser != ST_EVICT), out_tdata[101:38] == 64'd0)
  `GLC_ASSERT_NEXT(a_one_request, in_tvalid && in_tready, !in_tready)
  `GLC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind glyph_cell_cache_lru_core glc_checker u_glc_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tuser, .out_tdata
);
`default_nettype wire
